// ===== hw/rtl/dqkd_pkg.sv =====
// Shared types and codes for the double-ended queue with key delete.
// Used by dqkd_cell and double_ended_queue_with_key_delete; no dependencies.
package dqkd_pkg;

	// Field widths fixed by the item format
	localparam int VAL_W = 32;
	localparam int OP_W  = 3;
	localparam int POS_W = 4;
	localparam int CNT_W = 5;
	localparam int ST_W  = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR      = 3'd6;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK    = 2'd0;
	localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
	localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

	// Per-cycle command broadcast along the cell chain
	typedef logic [2:0] cmd_t;
	localparam cmd_t CMD_HOLD       = 3'd0;
	localparam cmd_t CMD_PUSH_BACK  = 3'd1;
	localparam cmd_t CMD_PUSH_FRONT = 3'd2;
	localparam cmd_t CMD_SHIFT_DOWN = 3'd3;
	localparam cmd_t CMD_ROTATE     = 3'd4;

	typedef struct packed {
		cmd_t             cmd;
		logic [VAL_W-1:0] wdata;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/dqkd_cell.sv =====
// One storage cell of the queue chain: holds one entry and trades it with its neighbors.
// Depends on dqkd_pkg for the command codes and the control struct.
module dqkd_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 5
) (
	input  logic                     clk,
	input  dqkd_pkg::cell_ctl_t      ctl,
	input  logic [CW-1:0]            count,
	input  logic [dqkd_pkg::VAL_W-1:0] left,
	input  logic [dqkd_pkg::VAL_W-1:0] right,
	input  logic [dqkd_pkg::VAL_W-1:0] front,
	output logic [dqkd_pkg::VAL_W-1:0] data
);

	logic [dqkd_pkg::VAL_W-1:0] data_q;

	// Pick the next entry from the broadcast command
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			dqkd_pkg::CMD_HOLD: begin
				data_q <= data_q;
			end
			dqkd_pkg::CMD_PUSH_BACK: begin
				if (count == CW'(INDEX)) begin
					data_q <= ctl.wdata;
				end
			end
			dqkd_pkg::CMD_PUSH_FRONT: begin
				data_q <= left;
			end
			dqkd_pkg::CMD_SHIFT_DOWN: begin
				data_q <= right;
			end
			dqkd_pkg::CMD_ROTATE: begin
				// last live cell takes the front entry, the rest move toward the front
				if (count == CW'(INDEX + 1)) begin
					data_q <= front;
				end else begin
					data_q <= right;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule

// ===== hw/rtl/double_ended_queue_with_key_delete.sv =====
// Bounded double-ended queue with key search and delete, built as a chain of cells.
// Push back, push front, pop front, clear and any empty/full/no-entry case go straight to the
// result register; pop back, find and delete first step the chain once per entry held at
// accept, as the chain rotates one entry per cycle past the front compare.
// Throughput: one beat per cycle for non-rotating operations unless the result side stalls;
// reset clears entry count and handshake state; cell contents stay undefined until written.
module double_ended_queue_with_key_delete #(
	parameter int DEPTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [dqkd_pkg::OP_W-1:0]         op,
	input  logic signed [dqkd_pkg::VAL_W-1:0] value,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic signed [dqkd_pkg::VAL_W-1:0] popped_value,
	output logic                              found,
	output logic [dqkd_pkg::POS_W-1:0]        position,
	output logic [dqkd_pkg::ST_W-1:0]         status,
	output logic [dqkd_pkg::CNT_W-1:0]        entry_count
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH);
	localparam int EW = (CW > dqkd_pkg::CNT_W) ? CW : dqkd_pkg::CNT_W;
	localparam int PW = (SW > dqkd_pkg::POS_W) ? SW : dqkd_pkg::POS_W;

	localparam logic SQ_IDLE = 1'b0;
	localparam logic SQ_ROT  = 1'b1;

	logic                        state_q;
	logic [CW-1:0]               count_q;
	logic [CW-1:0]               total_q;
	logic [SW-1:0]               step_q;
	logic [dqkd_pkg::OP_W-1:0]   op_q;
	logic [dqkd_pkg::VAL_W-1:0]  key_q;
	logic                        hit_q;
	logic [SW-1:0]               hitpos_q;

	logic                        rsp_valid_q;
	logic [dqkd_pkg::VAL_W-1:0]  popped_q;
	logic                        found_q;
	logic [dqkd_pkg::POS_W-1:0]  position_q;
	logic [dqkd_pkg::ST_W-1:0]   status_q;
	logic [dqkd_pkg::CNT_W-1:0]  entry_count_q;

	logic [dqkd_pkg::VAL_W-1:0]  data [DEPTH];
	dqkd_pkg::cell_ctl_t         ctl;

	logic                        req_acc;
	logic                        full;
	logic                        empty;
	logic                        last_step;
	logic                        hit;
	logic                        go_rot;
	logic                        fin;
	logic [CW-1:0]               count_d;
	logic [dqkd_pkg::VAL_W-1:0]  r_pop;
	logic                        r_found;
	logic [SW-1:0]               r_pos;
	logic [dqkd_pkg::ST_W-1:0]   r_status;
	logic [EW-1:0]               cnt_ext;
	logic [PW-1:0]               pos_ext;

	// Take a beat only when idle and the result register is free or draining
	assign req_stall = (state_q != SQ_IDLE) || (rsp_valid_q && rsp_stall);
	assign req_acc   = req_valid && !req_stall;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign last_step = ((CW'(step_q) + CW'(1)) == total_q);
	assign hit       = (data[0] == key_q) && !hit_q;

	// Decode the operation into a chain command and the result fields
	always_comb begin
		ctl.cmd   = dqkd_pkg::CMD_HOLD;
		ctl.wdata = value;
		count_d   = count_q;
		go_rot    = 1'b0;
		fin       = 1'b0;
		r_pop     = '0;
		r_found   = 1'b0;
		r_pos     = '0;
		r_status  = dqkd_pkg::ST_OK;
		if (state_q == SQ_IDLE) begin
			if (req_acc) begin
				fin = 1'b1;
				case (op)
					dqkd_pkg::OP_PUSH_BACK: begin
						if (full) begin
							r_status = dqkd_pkg::ST_FULL;
						end else begin
							ctl.cmd = dqkd_pkg::CMD_PUSH_BACK;
							count_d = count_q + CW'(1);
						end
					end
					dqkd_pkg::OP_PUSH_FRONT: begin
						if (full) begin
							r_status = dqkd_pkg::ST_FULL;
						end else begin
							ctl.cmd = dqkd_pkg::CMD_PUSH_FRONT;
							count_d = count_q + CW'(1);
						end
					end
					dqkd_pkg::OP_POP_FRONT: begin
						if (empty) begin
							r_status = dqkd_pkg::ST_EMPTY;
						end else begin
							r_pop   = data[0];
							ctl.cmd = dqkd_pkg::CMD_SHIFT_DOWN;
							count_d = count_q - CW'(1);
						end
					end
					dqkd_pkg::OP_POP_BACK: begin
						if (empty) begin
							r_status = dqkd_pkg::ST_EMPTY;
						end else begin
							go_rot = 1'b1;
							fin    = 1'b0;
						end
					end
					dqkd_pkg::OP_FIND, dqkd_pkg::OP_DELETE: begin
						if (empty) begin
							r_status = dqkd_pkg::ST_MISS;
						end else begin
							go_rot = 1'b1;
							fin    = 1'b0;
						end
					end
					dqkd_pkg::OP_CLEAR: begin
						count_d = '0;
					end
					default: begin
						count_d = count_q;
					end
				endcase
			end
		end else begin
			fin = last_step;
			if (op_q == dqkd_pkg::OP_POP_BACK) begin
				// back entry reaches the front on the last step; drop it there
				if (last_step) begin
					r_pop   = data[0];
					ctl.cmd = dqkd_pkg::CMD_SHIFT_DOWN;
					count_d = count_q - CW'(1);
				end else begin
					ctl.cmd = dqkd_pkg::CMD_ROTATE;
				end
			end else begin
				if (hit && (op_q == dqkd_pkg::OP_DELETE)) begin
					ctl.cmd = dqkd_pkg::CMD_SHIFT_DOWN;
					count_d = count_q - CW'(1);
				end else begin
					ctl.cmd = dqkd_pkg::CMD_ROTATE;
				end
				r_found  = hit_q || hit;
				r_pos    = hit ? step_q : hitpos_q;
				r_status = (hit_q || hit) ? dqkd_pkg::ST_OK : dqkd_pkg::ST_MISS;
			end
		end
	end

	// Cell chain, front at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [dqkd_pkg::VAL_W-1:0] left_w;
		logic [dqkd_pkg::VAL_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = ctl.wdata;
		end else begin : g_mid_l
			assign left_w = data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = data[i];
		end else begin : g_mid_r
			assign right_w = data[i+1];
		end
		dqkd_cell #(
			.INDEX(i),
			.CW   (CW)
		) u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.count(count_q),
			.left (left_w),
			.right(right_w),
			.front(data[0]),
			.data (data[i])
		);
	end

	// Sequencer and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SQ_IDLE;
			count_q  <= '0;
			step_q   <= '0;
			total_q  <= '0;
			op_q     <= dqkd_pkg::OP_PUSH_BACK;
			hit_q    <= 1'b0;
			hitpos_q <= '0;
		end else begin
			count_q <= count_d;
			if (go_rot) begin
				state_q  <= SQ_ROT;
				step_q   <= '0;
				total_q  <= count_q;
				op_q     <= op;
				hit_q    <= 1'b0;
				hitpos_q <= '0;
			end else if (state_q == SQ_ROT) begin
				step_q <= step_q + SW'(1);
				if (hit) begin
					hit_q    <= 1'b1;
					hitpos_q <= step_q;
				end
				if (last_step) begin
					state_q <= SQ_IDLE;
				end
			end
		end
	end

	// Hold the search key for the rotation
	always_ff @(posedge clk) begin
		if (go_rot) begin
			key_q <= value;
		end
	end

	assign cnt_ext = EW'(count_d);
	assign pos_ext = PW'(r_pos);

	// Result register: load on finish, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fin) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_valid_q && !rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			popped_q      <= r_pop;
			found_q       <= r_found;
			position_q    <= pos_ext[dqkd_pkg::POS_W-1:0];
			status_q      <= r_status;
			entry_count_q <= cnt_ext[dqkd_pkg::CNT_W-1:0];
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign popped_value = popped_q;
	assign found        = found_q;
	assign position     = position_q;
	assign status       = status_q;
	assign entry_count  = entry_count_q;

	// Entry count stays within the chain
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count exceeds depth");

	// Result register is empty for the whole rotation
	a_rot_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_ROT) |-> !rsp_valid_q)
		else $error("result pending during rotation");

	// The last rotation step delivers a result
	a_rot_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SQ_ROT && last_step) |=> (rsp_valid && state_q == SQ_IDLE))
		else $error("rotation ended without a result");

	// A match always reports ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && found) |-> (status == dqkd_pkg::ST_OK))
		else $error("match with non-ok status");

	// A failed pop returns zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == dqkd_pkg::ST_EMPTY) |-> (popped_value == '0))
		else $error("empty pop returned data");

endmodule
